// ===== src/asic_tick_timer_interrupts_assert.svh =====
// Assertion helpers for the tick timer block.
// Both macros expect clk and arst_n in scope.
`ifndef ASIC_TICK_TIMER_INTERRUPTS_ASSERT_SVH
`define ASIC_TICK_TIMER_INTERRUPTS_ASSERT_SVH

// Same-cycle implication.
`define TTI_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tick timer check failed");

// Next-cycle implication.
`define TTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tick timer check failed");

`endif

// ===== src/tti_pkg.sv =====
package tti_pkg;

	localparam int TIMER_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int TICK_W = 10;
	localparam int FRAME_W = 4;
	localparam logic [FRAME_W-1:0] FRAME_LAST = 4'd11;

	localparam logic [CFG_IDX_W-1:0] CFG_NEWER_HW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OSC_CTRL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_INT_EN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_CTRL = 3'd4;

	// osc_control bits
	localparam int OSC_EN_BIT = 1;
	localparam int INT3_EN_BIT = 2;
	localparam int TIMER_EN_BIT = 3;
	localparam int MASK_BIT = 7;

	// link_int_enable bits
	localparam int LINK_OFF_BIT = 6;

	typedef struct packed {
		logic       newer_hardware;
		logic [7:0] osc_control;
		logic [7:0] timer_reload;
		logic [7:0] link_int_enable;
		logic [7:0] power_control;
	} cfg_t;

	typedef struct packed {
		logic       irq_one;
		logic       irq_three;
		logic       irq_four;
		logic       irq_five;
		logic       kbd_scan;
		logic       link_poll;
		logic       lcd_refresh;
		logic [7:0] timer_now;
		logic       frame_sync;
	} res_t;

endpackage

// ===== src/asic_tick_timer_interrupts.sv =====
// Tick timer and interrupt glue, one OSC2 tick per item.
// Each accepted item passes through the input register and then the result register;
// out_stall can hold it in the input register before out_valid rises.
// Throughput: 1 item per cycle; out_stall holds both stages and backs up into in_stall.
// Reset (arst_n low, asynchronous): config registers, timer and tick/frame counters
// clear to zero and both pipeline stages empty.
module asic_tick_timer_interrupts (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tti_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     link_status,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           irq_one,
	output logic                           irq_three,
	output logic                           irq_four,
	output logic                           irq_five,
	output logic                           kbd_scan,
	output logic                           link_poll,
	output logic                           lcd_refresh,
	output logic [7:0]                     timer_now,
	output logic                           frame_sync
);

	tti_pkg::cfg_t cfg;
	tti_pkg::res_t res_c, res_s2;
	logic          valid_s1, valid_s2;
	logic [7:0]    status_s1;
	logic          adv_s1;

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	tti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tti_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv_s1),
		.status (status_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			status_s1 <= link_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_c;
	end

	assign out_valid   = valid_s2;
	assign irq_one     = res_s2.irq_one;
	assign irq_three   = res_s2.irq_three;
	assign irq_four    = res_s2.irq_four;
	assign irq_five    = res_s2.irq_five;
	assign kbd_scan    = res_s2.kbd_scan;
	assign link_poll   = res_s2.link_poll;
	assign lcd_refresh = res_s2.lcd_refresh;
	assign timer_now   = res_s2.timer_now;
	assign frame_sync  = res_s2.frame_sync;

endmodule

// ===== src/tti_cfg.sv =====
module tti_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tti_pkg::CFG_DATA_W-1:0] cfg_data,
	output tti_pkg::cfg_t                  cfg
);

	tti_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tti_pkg::CFG_NEWER_HW:     cfg_q.newer_hardware  <= cfg_data[0];
				tti_pkg::CFG_OSC_CTRL:     cfg_q.osc_control     <= cfg_data;
				tti_pkg::CFG_TIMER_RELOAD: cfg_q.timer_reload    <= cfg_data;
				tti_pkg::CFG_LINK_INT_EN:  cfg_q.link_int_enable <= cfg_data;
				tti_pkg::CFG_POWER_CTRL:   cfg_q.power_control   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/tti_core.sv =====
module tti_core (
	input  logic          clk,
	input  logic          arst_n,
	input  tti_pkg::cfg_t cfg,
	input  logic          adv,
	input  logic [7:0]    status,
	output tti_pkg::res_t res
);

	logic [tti_pkg::TIMER_W-1:0] timer_q, timer_d;
	logic [tti_pkg::TICK_W-1:0]  tick_q, tick_d;
	logic [tti_pkg::FRAME_W-1:0] frame_q, frame_d;
	logic                        fbit_q, fbit_d;
	logic                        osc_on, tmr_on, allow, blocked, link_on;

	always_comb begin
		osc_on  = cfg.osc_control[tti_pkg::OSC_EN_BIT];
		tmr_on  = cfg.osc_control[tti_pkg::TIMER_EN_BIT];
		link_on = !cfg.link_int_enable[tti_pkg::LINK_OFF_BIT];
		blocked = cfg.power_control[2] && !cfg.power_control[1];
		allow   = !cfg.osc_control[tti_pkg::MASK_BIT] && (!cfg.newer_hardware || !blocked);

		timer_d = timer_q;
		tick_d  = tick_q;
		frame_d = frame_q;
		fbit_d  = fbit_q;
		res     = '0;

		if (!osc_on) begin
			res.kbd_scan = 1'b1;
		end else begin
			if (tmr_on) begin
				// reload on the tick after reaching zero
				if (timer_q == '0)
					timer_d = tti_pkg::TIMER_W'(cfg.timer_reload);
				else
					timer_d = timer_q + 1'b1;
				tick_d  = tick_q + 1'b1;
				frame_d = (frame_q >= tti_pkg::FRAME_LAST) ? '0 : frame_q + 1'b1;
			end
			if (frame_d == '0 && cfg.newer_hardware)
				fbit_d = ~fbit_q;

			res.irq_one   = (tick_d[1:0] == 2'd0) && allow;
			res.irq_three = (tick_d == '0) && cfg.osc_control[tti_pkg::INT3_EN_BIT] && allow;
			res.link_poll = link_on;
			res.irq_four  = link_on && ((cfg.link_int_enable[3] && status[7]) ||
			                            (cfg.link_int_enable[2] && status[3]) ||
			                            (cfg.link_int_enable[1] && status[6]) ||
			                            (cfg.link_int_enable[0] && status[5]));
			res.irq_five    = (timer_d == '0) && allow;
			res.kbd_scan    = (tick_d[2:0] == 3'd0);
			res.lcd_refresh = !cfg.newer_hardware && (tick_d[3:0] == 4'd0);
		end
		res.timer_now  = timer_d[7:0];
		res.frame_sync = fbit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			tick_q  <= '0;
			frame_q <= '0;
			fbit_q  <= 1'b0;
		end else if (adv) begin
			timer_q <= timer_d;
			tick_q  <= tick_d;
			frame_q <= frame_d;
			fbit_q  <= fbit_d;
		end
	end

endmodule

// ===== src/tti_checker.sv =====
`include "asic_tick_timer_interrupts_assert.svh"

module tti_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       irq_one,
	input logic       irq_three,
	input logic       irq_four,
	input logic       kbd_scan,
	input logic       link_poll,
	input logic       lcd_refresh,
	input logic [7:0] timer_now
);

	// a stalled result item holds
	`TTI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(timer_now))

	// tick phase zero is also a multiple of four
	`TTI_ASSERT_IMPL(a_int3_has_int1, out_valid && irq_three, irq_one)

	// LCD phase (mod 16) implies keyboard phase (mod 8)
	`TTI_ASSERT_IMPL(a_lcd_has_kbd, out_valid && lcd_refresh, kbd_scan)

	// int4 only while the link is enabled
	`TTI_ASSERT_IMPL(a_int4_has_poll, out_valid && irq_four, link_poll)

endmodule

bind asic_tick_timer_interrupts tti_checker u_tti_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.irq_one     (irq_one),
	.irq_three   (irq_three),
	.irq_four    (irq_four),
	.kbd_scan    (kbd_scan),
	.link_poll   (link_poll),
	.lcd_refresh (lcd_refresh),
	.timer_now   (timer_now)
);
